// ===== rtl/ifmt_pkg.sv =====
// shared constants, types and helpers for the integer field formatter
package ifmt_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int MAX_FIELD_WIDTH = 32;

    // character counter width, holds the longest field (up to 32 characters)
    localparam int CNT_W   = 7;
    localparam int FIELD_W = 6;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_SDEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDEC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_OCT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd3;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    typedef struct packed {
        logic              load;
        logic [FUNC_W-1:0] func;
        logic              dabble;
        logic              norm;
        logic              pop;
    } t_dig_ctrl;

    typedef struct packed {
        logic             neg;
        logic             zpad;
        logic             ladj;
        logic [CNT_W-1:0] width;
    } t_emit_cfg;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== rtl/ifmt_if.sv =====
// valid/ready channel interfaces for conversion requests and output characters
interface ifmt_in_if #(
    parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [ifmt_pkg::FUNC_W-1:0]  func;
    logic [VALUE_BITS-1:0]        value;
    logic [ifmt_pkg::FIELD_W-1:0] field_width;
    logic                         zero_pad;
    logic                         left_adjust;

    modport source (
        output valid, func, value, field_width, zero_pad, left_adjust,
        input  ready
    );
    modport sink (
        input  valid, func, value, field_width, zero_pad, left_adjust,
        output ready
    );
endinterface

interface ifmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink (input valid, out_char, last, output ready);
endinterface

// ===== rtl/ifmt_digit_unit.sv =====
// digit register: double-dabble step, octal/hex load, leading zero strip, digit pop
module ifmt_digit_unit #(
    parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  ifmt_pkg::t_dig_ctrl        i_ctrl,
    input  logic [VALUE_BITS-1:0]      i_mag,
    output logic [3:0]                 o_top_digit,
    output logic [ifmt_pkg::CNT_W-1:0] o_ndig,
    output logic                       o_norm_done,
    input  logic                       i_rst_n
);
    import ifmt_pkg::*;

    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int DW   = NDIG * 4;
    localparam int OW   = NDIG * 3;
    localparam int CW   = $clog2(NDIG + 1);

    logic [DW-1:0]         r_bcd, n_bcd;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [CW-1:0]         r_ndig, n_ndig;
    logic [DW-1:0]         w_oct;
    logic [OW-1:0]         w_oct_src;
    logic [DW-1:0]         w_adj;

    assign w_oct_src = OW'(i_mag);

    genvar g;
    generate
        for (g = 0; g < NDIG; g++) begin : g_digit
            assign w_oct[4*g +: 4] = {1'b0, w_oct_src[3*g +: 3]};
            // add 3 to every digit of 5 or more before the shift
            assign w_adj[4*g +: 4] = (r_bcd[4*g +: 4] >= 4'd5) ?
                                     r_bcd[4*g +: 4] + 4'd3 : r_bcd[4*g +: 4];
        end
    endgenerate

    assign o_top_digit = r_bcd[DW-1 -: 4];
    assign o_norm_done = (o_top_digit != 4'd0) || (r_ndig == CW'(1));
    assign o_ndig      = CNT_W'(r_ndig);

    always_comb begin
        n_bcd  = r_bcd;
        n_bin  = r_bin;
        n_ndig = r_ndig;
        if (i_ctrl.load) begin
            n_ndig = CW'(NDIG);
            n_bin  = i_mag;
            case (i_ctrl.func)
                FUNC_OCT: n_bcd = w_oct;
                FUNC_HEX: n_bcd = DW'(i_mag);
                default:  n_bcd = '0;
            endcase
        end else if (i_ctrl.dabble) begin
            n_bcd = {w_adj[DW-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_ctrl.norm) begin
            if (!o_norm_done) begin
                n_bcd  = {r_bcd[DW-5:0], 4'd0};
                n_ndig = r_ndig - CW'(1);
            end
        end else if (i_ctrl.pop) begin
            n_bcd = {r_bcd[DW-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
        if (!i_rst_n) begin
            r_ndig <= CW'(1);
        end else begin
            r_ndig <= n_ndig;
        end
    end

endmodule

// ===== rtl/ifmt_emit.sv =====
// character sequencer: sign, padding and digits in field order into an output register
module ifmt_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ifmt_pkg::t_emit_cfg        i_cfg,
    input  logic [ifmt_pkg::CNT_W-1:0] i_ndig,
    input  logic [3:0]                 i_digit,
    output logic                       o_pop,
    output logic                       o_busy,
    ifmt_out_if.source                 o_out
);
    import ifmt_pkg::*;

    logic             r_active, n_active;
    logic             r_valid, n_valid;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;
    logic             r_sign, n_sign;
    logic [CNT_W-1:0] r_pad, n_pad;
    logic [CNT_W-1:0] r_dig, n_dig;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] w_len;
    logic [CNT_W-1:0] w_padn;
    logic             w_fire;
    logic             w_pre_pad;
    logic [7:0]       w_padc;

    assign w_len     = i_ndig + CNT_W'(i_cfg.neg);
    assign w_padn    = (i_cfg.width > w_len) ? i_cfg.width - w_len : '0;
    assign w_fire    = r_active && (!r_valid || o_out.ready);
    // space padding right aligned goes ahead of the sign
    assign w_pre_pad = !i_cfg.ladj && !(i_cfg.neg && i_cfg.zpad);
    assign w_padc    = i_cfg.zpad ? CHAR_ZERO : CHAR_SPACE;

    always_comb begin
        n_active = r_active;
        n_valid  = r_valid;
        n_char   = r_char;
        n_last   = r_last;
        n_sign   = r_sign;
        n_pad    = r_pad;
        n_dig    = r_dig;
        n_rem    = r_rem;
        o_pop    = 1'b0;
        if (r_valid && o_out.ready) begin
            n_valid = 1'b0;
        end
        if (i_start) begin
            n_active = 1'b1;
            n_sign   = i_cfg.neg;
            n_pad    = w_padn;
            n_dig    = i_ndig;
            n_rem    = w_len + w_padn;
        end else if (w_fire) begin
            n_valid = 1'b1;
            n_last  = (r_rem == CNT_W'(1));
            n_rem   = r_rem - CNT_W'(1);
            if (r_rem == CNT_W'(1)) begin
                n_active = 1'b0;
            end
            if (r_sign && !(w_pre_pad && r_pad != '0)) begin
                n_char = CHAR_MINUS;
                n_sign = 1'b0;
            end else if (r_pad != '0 && !i_cfg.ladj) begin
                n_char = w_padc;
                n_pad  = r_pad - CNT_W'(1);
            end else if (r_dig != '0) begin
                n_char = digit_char(i_digit);
                n_dig  = r_dig - CNT_W'(1);
                o_pop  = 1'b1;
            end else begin
                n_char = w_padc;
                n_pad  = r_pad - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_sign <= n_sign;
        r_pad  <= n_pad;
        r_dig  <= n_dig;
        r_rem  <= n_rem;
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    assign o_busy         = r_active;
    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.last     = r_last;

endmodule

// ===== rtl/integer_field_formatter_top.sv =====
// integer field formatter: takes one conversion request, streams its ascii characters
// decimal kinds convert by double dabble over all VALUE_BITS bits, octal and hex load at once;
// leading zero digits are then stripped one per cycle (at most (VALUE_BITS+2)/3 - 1 of them)
// and characters leave one per cycle while the output is ready; one request at a time,
// ready only when idle
// the last character may wait in the output register while the next request is taken
// reset (synchronous, active low) clears the sequencer and the output valid
module integer_field_formatter_top #(
    parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ifmt_in_if.sink    i_in,
    ifmt_out_if.source o_out
);
    import ifmt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int BW = $clog2(VALUE_BITS);

    logic [1:0]            r_state, n_state;
    logic [BW-1:0]         r_cnt, n_cnt;
    t_emit_cfg             r_cfg, n_cfg;
    t_dig_ctrl             w_ctrl;
    logic                  w_accept;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic [CNT_W-1:0]      w_width;
    logic [3:0]            w_digit;
    logic [CNT_W-1:0]      w_ndig;
    logic                  w_norm_done;
    logic                  w_pop;
    logic                  w_busy;
    logic                  w_start;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_neg      = (i_in.func == FUNC_SDEC) && i_in.value[VALUE_BITS-1];
    assign w_mag      = w_neg ? (~i_in.value + VALUE_BITS'(1)) : i_in.value;
    assign w_width    = (CNT_W'(i_in.field_width) > CNT_W'(MAX_FIELD_WIDTH)) ?
                        CNT_W'(MAX_FIELD_WIDTH) : CNT_W'(i_in.field_width);
    assign w_start    = (r_state == ST_NORM) && w_norm_done;

    always_comb begin
        w_ctrl.load   = w_accept;
        w_ctrl.func   = i_in.func;
        w_ctrl.dabble = (r_state == ST_CONV);
        w_ctrl.norm   = (r_state == ST_NORM);
        w_ctrl.pop    = w_pop;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cfg   = r_cfg;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cfg.neg   = w_neg;
                    n_cfg.zpad  = i_in.zero_pad;
                    n_cfg.ladj  = i_in.left_adjust;
                    n_cfg.width = w_width;
                    n_cnt       = BW'(VALUE_BITS - 1);
                    if (i_in.func == FUNC_OCT || i_in.func == FUNC_HEX) begin
                        n_state = ST_NORM;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_cnt = r_cnt - BW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (w_norm_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_cfg <= n_cfg;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    ifmt_digit_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_mag       (w_mag),
        .o_top_digit (w_digit),
        .o_ndig      (w_ndig),
        .o_norm_done (w_norm_done),
        .i_rst_n     (i_rst_n)
    );

    ifmt_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cfg   (r_cfg),
        .i_ndig  (w_ndig),
        .i_digit (w_digit),
        .o_pop   (w_pop),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

    // a new transaction is never taken while the emitter still has characters of the previous one to produce
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy)
        else $error("request taken while emitter busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    a_start_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> (w_ndig != '0))
        else $error("emitter started with no digits");

    a_pop_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_state == ST_EMIT))
        else $error("digit popped outside emit phase");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the integer field formatter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ifmt_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [31:0]        value;
        logic [FIELD_W-1:0] field_width;
        logic               zero_pad;
        logic               left_adjust;
    } t_conv_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_field_char;

    typedef struct {
        t_conv_req req;
        string     text;
    } t_dir_row;

    localparam int N_DIR        = 24;
    localparam int N_RANDOM     = 126;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 100;
    localparam int DRAIN_CYCLES = 80;

    // empty text means the row is checked against the predictor
    t_dir_row dir_tab [N_DIR] = '{
        '{'{FUNC_SDEC, 32'h0000_0000, 6'd0,  1'b0, 1'b0}, "0"},
        '{'{FUNC_UDEC, 32'h0000_0000, 6'd0,  1'b0, 1'b0}, "0"},
        '{'{FUNC_OCT,  32'h0000_0000, 6'd0,  1'b0, 1'b0}, "0"},
        '{'{FUNC_HEX,  32'h0000_0000, 6'd0,  1'b0, 1'b0}, "0"},
        '{'{FUNC_SDEC, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0}, "2147483647"},
        '{'{FUNC_SDEC, 32'h8000_0000, 6'd0,  1'b0, 1'b0}, "-2147483648"},
        '{'{FUNC_SDEC, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0}, "-1"},
        '{'{FUNC_UDEC, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0}, "4294967295"},
        '{'{FUNC_OCT,  32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0}, "37777777777"},
        '{'{FUNC_HEX,  32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0}, "FFFFFFFF"},
        '{'{FUNC_HEX,  32'h00AB_CDEF, 6'd0,  1'b0, 1'b0}, "ABCDEF"},
        '{'{FUNC_HEX,  32'h8000_0000, 6'd0,  1'b0, 1'b0}, "80000000"},
        '{'{FUNC_SDEC, 32'hFFFF_FF85, 6'd6,  1'b1, 1'b0}, "-00123"},
        '{'{FUNC_SDEC, 32'hFFFF_FF85, 6'd6,  1'b0, 1'b0}, "  -123"},
        '{'{FUNC_SDEC, 32'hFFFF_FF85, 6'd6,  1'b1, 1'b1}, "-12300"},
        '{'{FUNC_UDEC, 32'd42,        6'd5,  1'b0, 1'b1}, "42   "},
        '{'{FUNC_UDEC, 32'd42,        6'd5,  1'b1, 1'b0}, "00042"},
        '{'{FUNC_UDEC, 32'd12345,     6'd3,  1'b0, 1'b0}, "12345"},
        '{'{FUNC_UDEC, 32'd7,         6'd1,  1'b0, 1'b0}, "7"},
        '{'{FUNC_SDEC, 32'd5,         6'd0,  1'b1, 1'b0}, "5"},
        '{'{FUNC_UDEC, 32'd7,         6'd63, 1'b1, 1'b0}, ""},
        '{'{FUNC_HEX,  32'hDEAD_BEEF, 6'd32, 1'b0, 1'b1}, ""},
        '{'{FUNC_SDEC, 32'h8000_0000, 6'd32, 1'b1, 1'b0}, ""},
        '{'{FUNC_OCT,  32'd8,         6'd33, 1'b0, 1'b0}, ""}
    };

    logic i_clk;
    logic i_rst_n;

    ifmt_in_if  in_ch ();
    ifmt_out_if out_ch ();

    integer_field_formatter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_field_char pending_chars [$];
    int          err_count = 0;
    int          rx_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // most gaps short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // characters of one conversion, in the order they leave the block
    function automatic void predict_field(input t_conv_req c, output logic [7:0] chars [$]);
        logic [7:0]  digits [$];
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  d;
        logic [7:0]  pad_char;
        logic        neg;
        int          width;
        int          len;
        int          padn;
        chars    = {};
        mag      = c.value;
        neg      = 1'b0;
        radix    = (c.func == FUNC_OCT) ? 32'd8 : (c.func == FUNC_HEX) ? 32'd16 : 32'd10;
        pad_char = c.zero_pad ? CHAR_ZERO : CHAR_SPACE;
        if (c.func == FUNC_SDEC && c.value[31]) begin
            neg = 1'b1;
            mag = -c.value;
        end
        do begin
            d = 4'(mag % radix);
            digits.push_front((d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d) - 8'd10);
            mag = mag / radix;
        end while (mag != 0);
        width = (c.field_width > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(c.field_width);
        len   = digits.size() + (neg ? 1 : 0);
        padn  = (width > len) ? width - len : 0;
        if (!c.left_adjust) begin
            // zero padding goes between the sign and the digits
            if (neg && c.zero_pad) chars.push_back(CHAR_MINUS);
            repeat (padn) chars.push_back(pad_char);
            if (neg && !c.zero_pad) chars.push_back(CHAR_MINUS);
            foreach (digits[i]) chars.push_back(digits[i]);
        end else begin
            if (neg) chars.push_back(CHAR_MINUS);
            foreach (digits[i]) chars.push_back(digits[i]);
            repeat (padn) chars.push_back(pad_char);
        end
    endfunction

    task automatic offer_conversion(input t_conv_req c, input string text, input int gap);
        logic [7:0] chars [$];
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= c.func;
        in_ch.value       <= c.value;
        in_ch.field_width <= c.field_width;
        in_ch.zero_pad    <= c.zero_pad;
        in_ch.left_adjust <= c.left_adjust;
        do @(posedge i_clk); while (!in_ch.ready);
        if (text.len() == 0) begin
            predict_field(c, chars);
        end else begin
            for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
        end
        foreach (chars[i]) pending_chars.push_back('{chars[i], i == chars.size() - 1});
    endtask

    // stimulus
    initial begin
        t_conv_req c;
        int        r;
        int        gap;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_SDEC;
        in_ch.value       = '0;
        in_ch.field_width = '0;
        in_ch.zero_pad    = 1'b0;
        in_ch.left_adjust = 1'b0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            offer_conversion(dir_tab[i].req, dir_tab[i].text, pick_gap());
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            c.func = FUNC_W'($urandom_range(0, 3));
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2, 3: c.value = $urandom;
                4, 5:       c.value = $urandom_range(0, 999);
                6:          c.value = -$urandom_range(1, 999);
                7: begin
                    case ($urandom_range(0, 5))
                        0:       c.value = 32'h0000_0000;
                        1:       c.value = 32'h0000_0001;
                        2:       c.value = 32'h7FFF_FFFF;
                        3:       c.value = 32'h8000_0000;
                        4:       c.value = 32'h8000_0001;
                        default: c.value = 32'hFFFF_FFFF;
                    endcase
                end
                8:       c.value = 32'h1 << $urandom_range(0, 31);
                default: c.value = $urandom >> $urandom_range(0, 31);
            endcase
            // mostly short fields, a few wide and a few past saturation
            r = $urandom_range(0, 9);
            if (r < 7) c.field_width = FIELD_W'($urandom_range(0, 12));
            else if (r < 9) c.field_width = FIELD_W'($urandom_range(13, 32));
            else c.field_width = FIELD_W'($urandom_range(33, 63));
            c.zero_pad    = 1'($urandom_range(0, 1));
            c.left_adjust = 1'($urandom_range(0, 1));
            // every third block of 25 runs back to back
            gap = ((i / 25) % 3 == 2) ? 0 : pick_gap();
            offer_conversion(c, "", gap);
        end
        in_ch.valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // output ready, with one long hold-off so the block backs up into its input
    initial begin
        bit held;
        int stall;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && rx_count >= HOLD_AT) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 100)) @(posedge i_clk);
                else repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // compare every output transaction with the oldest pending character
    always @(posedge i_clk) begin
        t_field_char want;
        if (!i_rst_n) begin
            rx_count <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            rx_count <= rx_count + 1;
            if (pending_chars.size() == 0) begin
                $error("unexpected transaction: out_char %h last %b", out_ch.out_char,
                       out_ch.last);
                err_count++;
            end else begin
                want = pending_chars.pop_front();
                if (out_ch.out_char !== want.ch) begin
                    $error("out_char mismatch: expected %h actual %h", want.ch,
                           out_ch.out_char);
                    err_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last mismatch: expected %b actual %b", want.last, out_ch.last);
                    err_count++;
                end
            end
        end
    end

endmodule
